/* hw/rtl/cdfd_pkg.sv */
`default_nettype none

package cdfd_pkg;

  localparam int MAX_TAPS = 64;
  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TAP_COUNT   = 2'd0;
  localparam logic [1:0] REG_DECIMATION  = 2'd1;
  localparam logic [1:0] REG_ROT_INCR_RE = 2'd2;
  localparam logic [1:0] REG_ROT_INCR_IM = 2'd3;

  // Input item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } cpx_t;

  // Operands of the shared complex product unit
  typedef struct packed {
    logic signed [17:0] re;
    logic signed [17:0] im;
  } op_t;

  // Partial products, kept modulo 2^32
  typedef struct packed {
    logic [31:0] rr;
    logic [31:0] ii;
    logic [31:0] ri;
    logic [31:0] ir;
  } prod_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic step;
  } cell_ctl_t;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MAC     = 8'b0000_0010,
    S_DRAIN   = 8'b0000_0100,
    S_ROUND   = 8'b0000_1000,
    S_ROT_MUL = 8'b0001_0000,
    S_ROT_SUM = 8'b0010_0000,
    S_PH_SUM  = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  // Q30 to Q15: add half an LSB, arithmetic shift right by 15
  function automatic logic signed [17:0] rnd15(input logic [31:0] v);
    logic [32:0] t;
    t = {v[31], v} + 33'd16384;
    return t[32:15];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic op_t ext_cpx(input cpx_t c);
    op_t o;
    o.re = {{2{c.re[15]}}, c.re};
    o.im = {{2{c.im[15]}}, c.im};
    return o;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cdfd_cell.sv */
`default_nettype none

module cdfd_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdfd_pkg::cell_ctl_t ctl,
  input  wire cdfd_pkg::cpx_t    win_in,
  input  wire cdfd_pkg::cpx_t    shd_in,
  output cdfd_pkg::cpx_t         win_out,
  output cdfd_pkg::cpx_t         shd_out
);

  cdfd_pkg::cpx_t win_r;
  cdfd_pkg::cpx_t shd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= win_in;
    end
  end

  // Snapshot the updated window, then walk it toward the read end
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shd_r <= win_in;
    end else if (ctl.step) begin
      shd_r <= shd_in;
    end
  end

  assign win_out = win_r;
  assign shd_out = shd_r;

endmodule

`default_nettype wire

/* hw/rtl/cdfd_cmul.sv */
`default_nettype none

module cdfd_cmul (
  input  wire logic          clk,
  input  wire cdfd_pkg::op_t a,
  input  wire cdfd_pkg::op_t b,
  output cdfd_pkg::prod_t    prod
);

  logic signed [35:0] rr;
  logic signed [35:0] ii;
  logic signed [35:0] ri;
  logic signed [35:0] ir;
  cdfd_pkg::prod_t    prod_r;

  always_comb begin
    rr = a.re * b.re;
    ii = a.im * b.im;
    ri = a.re * b.im;
    ir = a.im * b.re;
  end

  always_ff @(posedge clk) begin
    prod_r.rr <= rr[31:0];
    prod_r.ii <= ii[31:0];
    prod_r.ri <= ri[31:0];
    prod_r.ir <= ir[31:0];
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

/* hw/rtl/complex_decimating_fir_derotator_unit.sv */
// Complex decimating FIR with derotation, Q15 in and out.
// Input channel (in_valid/in_stall): each beat is a complex sample
// (in_kind low) or a coefficient write (in_kind high, tap in_coef_index).
// Coefficient writes and samples that complete no output are taken without a stall.
// A sample that completes an output holds in_stall high while the sum is
// formed: the single complex MAC steps through the N taps in use, fed by the
// shadow row of the tap cells, then the pipeline drains, the sum is rounded,
// derotation runs when it is on (product, sum, phasor advance), and the
// output register is loaded, which waits while that register is full and
// out_stall is high. The next beat is taken only once the result is loaded.
// Result channel (out_valid/out_stall): one output register; while
// out_stall holds a result the block keeps taking beats and only waits
// when a new result is ready and the register is still full.
// Configuration (cfg_we/cfg_index/cfg_data) is to be written only while idle; the block does not enforce this.
// Reset (rst_n low, synchronous) clears the sample window, counters and state,
// restores the configuration defaults and sets the phasor to one; coefficients
// stay undefined until written, so no clearing pass is needed.
`default_nettype none

module complex_decimating_fir_derotator_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_kind,
  input  wire logic signed [15:0]  in_sample_re,
  input  wire logic signed [15:0]  in_sample_im,
  input  wire logic [5:0]          in_coef_index,
  input  wire logic signed [15:0]  in_coef_re,
  input  wire logic signed [15:0]  in_coef_im,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [15:0]       out_re,
  output logic signed [15:0]       out_im,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [16:0]         cfg_data
);

  localparam int TAP_W = cdfd_pkg::TAP_W;
  localparam int CNT_W = cdfd_pkg::CNT_W;
  localparam int NTAP  = cdfd_pkg::MAX_TAPS;

  // Configuration registers
  logic [6:0]         tap_count_r;
  logic [7:0]         decimation_r;
  logic signed [16:0] rot_incr_re_r;
  logic signed [16:0] rot_incr_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r   <= 7'd64;
      decimation_r  <= 8'd1;
      rot_incr_re_r <= '0;
      rot_incr_im_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdfd_pkg::REG_TAP_COUNT:   tap_count_r   <= cfg_data[6:0];
        cdfd_pkg::REG_DECIMATION:  decimation_r  <= cfg_data[7:0];
        cdfd_pkg::REG_ROT_INCR_RE: rot_incr_re_r <= cfg_data;
        cdfd_pkg::REG_ROT_INCR_IM: rot_incr_im_r <= cfg_data;
      endcase
    end
  end

  cdfd_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [7:0]         phase_r, phase_nxt;
  logic [TAP_W-1:0]   j_r, j_nxt;
  logic [TAP_W-1:0]   nm1_r, nm1_nxt;
  logic [31:0]        acc_re_r, acc_re_nxt;
  logic [31:0]        acc_im_r, acc_im_nxt;
  cdfd_pkg::cpx_t     y_r, y_nxt;
  logic signed [17:0] ph_re_r, ph_re_nxt;
  logic signed [17:0] ph_im_r, ph_im_nxt;
  logic               iss_r, prd_r;
  logic               out_valid_r;
  cdfd_pkg::cpx_t     out_r;

  logic               in_acc;
  logic               out_load;
  logic               coef_we;
  logic               rot_en;
  logic [CNT_W-1:0]   n_cur;
  logic [CNT_W-1:0]   fill_inc;
  logic [7:0]         phase_inc;
  logic [TAP_W-1:0]   rd_addr;
  cdfd_pkg::cell_ctl_t ctl;
  cdfd_pkg::cpx_t     sample_in;
  cdfd_pkg::cpx_t     coef_in;
  cdfd_pkg::cpx_t     coef_q_r;
  cdfd_pkg::cpx_t     s_q_r;
  cdfd_pkg::op_t      op_a, op_b;
  cdfd_pkg::prod_t    prod;

  cdfd_pkg::cpx_t     win [NTAP];
  cdfd_pkg::cpx_t     shd [NTAP];
  cdfd_pkg::cpx_t     coef_mem [NTAP];

  assign sample_in.re = in_sample_re;
  assign sample_in.im = in_sample_im;
  assign coef_in.re   = in_coef_re;
  assign coef_in.im   = in_coef_im;

  assign in_stall = (state_r != cdfd_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rot_en   = (rot_incr_re_r != '0) || (rot_incr_im_r != '0);

  always_comb begin
    if (tap_count_r == 7'd0) begin
      n_cur = CNT_W'(1);
    end else if (tap_count_r > 7'(NTAP)) begin
      n_cur = CNT_W'(NTAP);
    end else begin
      n_cur = CNT_W'(tap_count_r);
    end
  end

  assign fill_inc  = fill_r + CNT_W'(1);
  assign phase_inc = phase_r + 8'd1;
  assign rd_addr   = nm1_r - j_r;

  // Row of tap cells: window shifts toward the old end, shadow toward cell 0
  for (genvar k = 0; k < NTAP; k++) begin : g_cell
    cdfd_pkg::cpx_t w_in;
    cdfd_pkg::cpx_t s_in;
    if (k == 0) begin : g_head
      assign w_in = sample_in;
    end else begin : g_body
      assign w_in = win[k-1];
    end
    if (k == NTAP - 1) begin : g_tail
      assign s_in = '0;
    end else begin : g_link
      assign s_in = shd[k+1];
    end
    cdfd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .win_in  (w_in),
      .shd_in  (s_in),
      .win_out (win[k]),
      .shd_out (shd[k])
    );
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[in_coef_index] <= coef_in;
    end
  end

  always_ff @(posedge clk) begin
    coef_q_r <= coef_mem[rd_addr];
    s_q_r    <= shd[0];
  end

  // Shared complex product unit operands
  always_comb begin
    if (state_r == cdfd_pkg::S_ROT_MUL) begin
      op_a = cdfd_pkg::ext_cpx(y_r);
      op_b.re = ph_re_r;
      op_b.im = ph_im_r;
    end else if (state_r == cdfd_pkg::S_ROT_SUM) begin
      op_a.re = ph_re_r;
      op_a.im = ph_im_r;
      op_b.re = {rot_incr_re_r[16], rot_incr_re_r};
      op_b.im = {rot_incr_im_r[16], rot_incr_im_r};
    end else begin
      op_a = cdfd_pkg::ext_cpx(coef_q_r);
      op_b = cdfd_pkg::ext_cpx(s_q_r);
    end
  end

  cdfd_cmul u_cmul (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    j_nxt      = j_r;
    nm1_nxt    = nm1_r;
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    y_nxt      = y_r;
    ph_re_nxt  = ph_re_r;
    ph_im_nxt  = ph_im_r;
    ctl        = '0;
    coef_we    = 1'b0;
    out_load   = 1'b0;

    if (prd_r) begin
      acc_re_nxt = acc_re_r + prod.rr - prod.ii;
      acc_im_nxt = acc_im_r + prod.ri + prod.ir;
    end

    unique case (state_r)
      cdfd_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_kind == cdfd_pkg::KIND_COEF) begin
            coef_we = (7'(in_coef_index) < 7'(NTAP));
          end else begin
            ctl.shift = 1'b1;
            if (fill_r < n_cur) begin
              fill_nxt = fill_inc;
              if (fill_inc >= n_cur) begin
                ctl.load  = 1'b1;
                phase_nxt = '0;
              end
            end else begin
              phase_nxt = phase_inc;
              if (phase_inc >= decimation_r) begin
                ctl.load  = 1'b1;
                phase_nxt = '0;
              end
            end
            if (ctl.load) begin
              acc_re_nxt = '0;
              acc_im_nxt = '0;
              j_nxt      = '0;
              nm1_nxt    = TAP_W'(n_cur - CNT_W'(1));
              state_nxt  = cdfd_pkg::S_MAC;
            end
          end
        end
      end
      cdfd_pkg::S_MAC: begin
        ctl.step = 1'b1;
        j_nxt    = j_r + TAP_W'(1);
        if (j_r == nm1_r) begin
          state_nxt = cdfd_pkg::S_DRAIN;
        end
      end
      cdfd_pkg::S_DRAIN: begin
        if (!iss_r && !prd_r) begin
          state_nxt = cdfd_pkg::S_ROUND;
        end
      end
      cdfd_pkg::S_ROUND: begin
        y_nxt.re  = cdfd_pkg::sat16(cdfd_pkg::rnd15(acc_re_r));
        y_nxt.im  = cdfd_pkg::sat16(cdfd_pkg::rnd15(acc_im_r));
        state_nxt = rot_en ? cdfd_pkg::S_ROT_MUL : cdfd_pkg::S_OUT;
      end
      cdfd_pkg::S_ROT_MUL: begin
        state_nxt = cdfd_pkg::S_ROT_SUM;
      end
      cdfd_pkg::S_ROT_SUM: begin
        y_nxt.re  = cdfd_pkg::sat16(cdfd_pkg::rnd15(prod.rr - prod.ii));
        y_nxt.im  = cdfd_pkg::sat16(cdfd_pkg::rnd15(prod.ri + prod.ir));
        state_nxt = cdfd_pkg::S_PH_SUM;
      end
      cdfd_pkg::S_PH_SUM: begin
        // Advance the phasor, no saturation
        ph_re_nxt = cdfd_pkg::rnd15(prod.rr - prod.ii);
        ph_im_nxt = cdfd_pkg::rnd15(prod.ri + prod.ir);
        state_nxt = cdfd_pkg::S_OUT;
      end
      cdfd_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = cdfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cdfd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdfd_pkg::S_IDLE;
      fill_r      <= '0;
      phase_r     <= '0;
      ph_re_r     <= 18'sd32768;
      ph_im_r     <= '0;
      iss_r       <= 1'b0;
      prd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      ph_re_r     <= ph_re_nxt;
      ph_im_r     <= ph_im_nxt;
      iss_r       <= (state_r == cdfd_pkg::S_MAC);
      prd_r       <= iss_r;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    nm1_r    <= nm1_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    y_r      <= y_nxt;
    if (out_load) begin
      out_r <= y_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_r.re;
  assign out_im    = out_r.im;

endmodule

`default_nettype wire
